[rtl/bfps_pkg.sv]
// ----------------------------------------------------------------------------
// bfps_pkg
// Shared constants, codes and helpers for the bit field pack/unpack store.
// ----------------------------------------------------------------------------
package bfps_pkg;

   // store geometry
   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(STORE_DEPTH + 1);
   localparam int BYTE_W      = 8;
   localparam int BITPOS_W    = 3;
   localparam int FULLPOS_W   = POS_W + BITPOS_W + 1;
   localparam int TOTAL_W     = 12;

   // payload widths
   localparam int OP_W     = 3;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;
   localparam int BCOUNT_W = 9;

   // widest legal field
   localparam logic [COUNT_W-1:0] FIELD_MAX = COUNT_W'(BYTE_W);

   // store end in bits
   localparam logic [FULLPOS_W-1:0] STORE_BITS = FULLPOS_W'(STORE_DEPTH * BYTE_W);

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_READ   = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WIDTH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // register map
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_REVERSE_BITS = 1'b0;

   // mirror a byte end for end
   function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

   // ones in the low n bits
   function automatic logic [BYTE_W-1:0] low_mask(input logic [COUNT_W-1:0] n);
      logic [2*BYTE_W-1:0] m;
      m = (2*BYTE_W)'(1) << n;
      m = m - (2*BYTE_W)'(1);
      return m[BYTE_W-1:0];
   endfunction

endpackage

[rtl/bfps_ram.sv]
// ----------------------------------------------------------------------------
// bfps_ram
// Generic simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bfps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bit_field_pack_unpack_store.sv]
// ----------------------------------------------------------------------------
// bit_field_pack_unpack_store
// LSB-first bit field writer and reader over a 256 byte store.
// ----------------------------------------------------------------------------
// One request is handled at a time, and each request gives one response.
// After reset the store is swept to zero, one byte a cycle, and req_ready stays
// low until the sweep is done. Rewind, unused codes, zero-width fields and
// rejected fields (width over 8, or past the end of the store) go from idle
// straight to the response state. Read and peek pass through READ0, and READ1
// when the field crosses into the next byte; add does the same and, when it
// crosses, writes the second byte in WRITE1. Clear writes zero to bytes 0
// through the byte position, one byte a cycle, and then answers. The store
// RAM has a registered read, and each touched byte is fetched and written
// back through its single read and write ports. The response register lets
// the next request come in while a response waits to be taken.
// ----------------------------------------------------------------------------
module bit_field_pack_unpack_store (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bfps_pkg::OP_W-1:0]             req_op,
   input  logic [bfps_pkg::BYTE_W-1:0]           req_bit_data,
   input  logic [bfps_pkg::COUNT_W-1:0]          req_bit_count,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bfps_pkg::BYTE_W-1:0]           rsp_read_value,
   output logic [bfps_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bfps_pkg::BCOUNT_W-1:0]         rsp_byte_count,
   output logic [bfps_pkg::TOTAL_W-1:0]          rsp_bits_processed,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bfps_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [bfps_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [bfps_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   import bfps_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ0,
      ST_READ1,
      ST_WRITE1,
      ST_CLEAR,
      ST_RESP
   } state_type;

   state_type                state_ff;
   logic [OP_W-1:0]          op_ff;
   logic [BYTE_W-1:0]        data_ff;
   logic [COUNT_W-1:0]       cnt_ff;
   logic                     spill_ff;
   logic [BYTE_W-1:0]        b0_ff;
   logic [BYTE_W-1:0]        hi_ff;
   logic [ADDR_W-1:0]        wr1_addr_ff;
   logic [BYTE_W-1:0]        value_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [POS_W-1:0]         bpos_ff;
   logic [BITPOS_W-1:0]      bitpos_ff;
   logic [TOTAL_W-1:0]       total_ff;
   logic                     reverse_ff;
   logic [ADDR_W-1:0]        clr_addr_ff;
   logic [ADDR_W-1:0]        clr_end_ff;
   logic                     rsp_valid_ff;
   logic [BYTE_W-1:0]        rsp_value_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [BCOUNT_W-1:0]      rsp_bcount_ff;
   logic [TOTAL_W-1:0]       rsp_total_ff;

   logic                     req_xfer;
   logic                     is_field;
   logic                     width_err;
   logic                     range_err;
   logic                     spill_in;
   logic [FULLPOS_W-1:0]     end_pos;
   logic [FULLPOS_W-1:0]     adv_pos;
   logic [ADDR_W-1:0]        clr_last;
   logic                     rsp_free;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [BYTE_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [BYTE_W-1:0]        ram_rd_data;
   logic [BYTE_W-1:0]        byte_rd;

   logic                     exec;
   logic [BYTE_W-1:0]        cur_b0;
   logic [BYTE_W-1:0]        cur_b1;
   logic [BYTE_W-1:0]        fmask;
   logic [2*BYTE_W-1:0]      window;
   logic [BYTE_W-1:0]        ext;
   logic [BYTE_W-1:0]        rd_field;
   logic [BYTE_W-1:0]        wr_field;
   logic [2*BYTE_W-1:0]      wr_shift;
   logic                     csr_wr;

   // store memory
   bfps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request decode and range checks
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign is_field  = (req_op == OP_ADD) || (req_op == OP_READ) || (req_op == OP_PEEK);
   assign width_err = (req_bit_count > FIELD_MAX);
   assign end_pos   = {1'b0, bpos_ff, bitpos_ff} + FULLPOS_W'(req_bit_count);
   assign range_err = (end_pos > STORE_BITS);
   assign spill_in  = ({1'b0, bitpos_ff} + req_bit_count) > FIELD_MAX;
   assign clr_last  = (bpos_ff >= POS_W'(STORE_DEPTH)) ? ADDR_W'(STORE_DEPTH - 1)
                                                       : bpos_ff[ADDR_W-1:0];
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // store read port: first byte on the request, second byte after it
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = bpos_ff[ADDR_W-1:0];
      if (req_xfer && is_field && !width_err && !range_err && (req_bit_count != '0)) begin
         ram_rd_en = 1'b1;
      end else if ((state_ff == ST_READ0) && spill_ff) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = bpos_ff[ADDR_W-1:0] + ADDR_W'(1);
      end
   end

   // store read data
   assign byte_rd = ram_rd_data;

   // field extract and insert over a two byte window
   assign exec     = ((state_ff == ST_READ0) && !spill_ff) || (state_ff == ST_READ1);
   assign cur_b0   = (state_ff == ST_READ0) ? byte_rd : b0_ff;
   assign cur_b1   = (state_ff == ST_READ1) ? byte_rd : '0;
   assign fmask    = low_mask(cnt_ff);
   assign window   = {cur_b1, cur_b0} >> bitpos_ff;
   assign ext      = window[BYTE_W-1:0] & fmask;
   assign rd_field = reverse_ff ? (flip_byte(ext) >> (FIELD_MAX - cnt_ff)) : ext;
   assign wr_field = reverse_ff ? (flip_byte(data_ff & fmask) >> (FIELD_MAX - cnt_ff))
                                : (data_ff & fmask);
   assign wr_shift = {{BYTE_W{1'b0}}, wr_field} << bitpos_ff;
   assign adv_pos  = {1'b0, bpos_ff, bitpos_ff} + FULLPOS_W'(cnt_ff);

   // store write port: first byte at execute, spilled byte in the cycle after it,
   // zero fill during the start-up sweep and the clear walk
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = bpos_ff[ADDR_W-1:0];
      ram_wr_data = cur_b0 ^ wr_shift[BYTE_W-1:0];
      if (exec && (op_ff == OP_ADD)) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == ST_WRITE1) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr1_addr_ff;
         ram_wr_data = hi_ff;
      end else if ((state_ff == ST_INIT) || (state_ff == ST_CLEAR)) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end
   end

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1] == CSR_IDX_REVERSE_BITS);
   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_REVERSE_BITS)
                   ? CSR_DATA_W'(reverse_ff) : '0;

   // sequencer, positions, store sweep and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_addr_ff  <= '0;
         bpos_ff      <= '0;
         bitpos_ff    <= '0;
         total_ff     <= '0;
         reverse_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            reverse_ff <= pwdata[0];
         end

         // response taken with no new one loaded this cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_INIT: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_xfer) begin
                  op_ff    <= req_op;
                  data_ff  <= req_bit_data;
                  cnt_ff   <= req_bit_count;
                  spill_ff <= spill_in;
                  value_ff <= '0;
                  if (is_field && width_err) begin
                     status_ff <= STATUS_WIDTH;
                     state_ff  <= ST_RESP;
                  end else if (is_field && range_err) begin
                     status_ff <= STATUS_RANGE;
                     state_ff  <= ST_RESP;
                  end else begin
                     status_ff <= STATUS_OK;
                     if (is_field && (req_bit_count != '0)) begin
                        state_ff <= ST_READ0;
                     end else if (req_op == OP_CLEAR) begin
                        clr_addr_ff <= '0;
                        clr_end_ff  <= clr_last;
                        state_ff    <= ST_CLEAR;
                     end else begin
                        state_ff <= ST_RESP;
                     end
                     if ((req_op == OP_REWIND) || (req_op == OP_CLEAR)) begin
                        bpos_ff   <= '0;
                        bitpos_ff <= '0;
                        total_ff  <= '0;
                     end
                  end
               end
            end

            ST_READ0: begin
               b0_ff <= byte_rd;
               if (spill_ff) begin
                  state_ff <= ST_READ1;
               end
            end

            ST_READ1: begin
               // second byte arrives, work done below
            end

            ST_WRITE1: begin
               state_ff <= ST_RESP;
            end

            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == clr_end_ff) begin
                  state_ff <= ST_RESP;
               end
            end

            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= value_ff;
                  rsp_status_ff <= status_ff;
                  rsp_bcount_ff <= BCOUNT_W'({1'b0, bpos_ff} + (POS_W + 1)'(1));
                  rsp_total_ff  <= total_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // field execute once the touched bytes are in hand
         if (exec) begin
            if (op_ff != OP_PEEK) begin
               bpos_ff   <= adv_pos[FULLPOS_W-2:BITPOS_W];
               bitpos_ff <= adv_pos[BITPOS_W-1:0];
               total_ff  <= total_ff + TOTAL_W'(cnt_ff);
            end
            if (op_ff == OP_ADD) begin
               hi_ff       <= cur_b1 ^ wr_shift[2*BYTE_W-1:BYTE_W];
               wr1_addr_ff <= bpos_ff[ADDR_W-1:0] + ADDR_W'(1);
               state_ff    <= spill_ff ? ST_WRITE1 : ST_RESP;
            end else begin
               value_ff <= rd_field;
               state_ff <= ST_RESP;
            end
         end
      end
   end

   // response outputs
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_byte_count     = rsp_bcount_ff;
   assign rsp_bits_processed = rsp_total_ff;

endmodule
